// ----- hdl/lav_pkg.sv -----
// shared types and constants for the look-at view matrix core
`default_nettype none

package lav_pkg;

  // width of every coordinate and matrix element on the ports
  localparam int COORD_W = 32;

  // magnitudes are scaled so that the largest lies in [2^(SCALE_W-1), 2^SCALE_W)
  localparam int SCALE_W = 30;

  localparam int ROW_W = 2;

  // row code of the translation row, the last one sent per request
  localparam logic [ROW_W-1:0] LAST_ROW = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] eye_x;
    logic signed [COORD_W-1:0] eye_y;
    logic signed [COORD_W-1:0] eye_z;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] up_x;
    logic signed [COORD_W-1:0] up_y;
    logic signed [COORD_W-1:0] up_z;
  } lav_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]          row_index;
    logic signed [COORD_W-1:0] col_zero;
    logic signed [COORD_W-1:0] col_one;
    logic signed [COORD_W-1:0] col_two;
    logic                      last_row;
  } lav_out_t;

endpackage

`default_nettype wire

// ----- hdl/look_at_view_matrix_core.sv -----
// top level of the left-handed look-at view matrix core
//
// use: each input request carries eye, target and up vectors in signed
// fixed point (FRAC_BITS fraction bits, lav_pkg::COORD_W bits wide). the
// core answers with four output requests, one per matrix row: rows 0 to 2
// hold the side, true-up and forward axes transposed, row 3 the negated
// dot products of those axes with the eye. last_row marks row 3; the
// fourth column (0,0,0,1) is implied
// the pipeline holds two normalisers, each a bit-per-stage square root
// of 31 stages and a bit-per-stage divider of FRAC_BITS+1 stages
// throughput: one input request per cycle enters the pipeline while
// in_ready is high; a new request is taken only once the last row of the
// held matrix leaves, as the output port sends one row a cycle from the
// row holding register while out_ready is high
// reset: rst_n clears every valid flag and the row counter; no clearing
// pass, data registers are left as they are
// stall: when the receiver holds out_ready low, the holding register keeps
// its row and the whole pipeline freezes together with in_ready, so no
// request is lost or repeated
`default_nettype none

module look_at_view_matrix_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lav_pkg::lav_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lav_pkg::lav_out_t out_data
);
  import lav_pkg::*;

  localparam int W    = COORD_W;
  localparam int F    = FRAC_BITS;
  localparam int ZW   = F + 2;            // unit axis component
  localparam int AW   = F + 3;            // true-up component
  localparam int US   = SCALE_W + 1;      // scaled up component, signed
  localparam int PXW  = US + ZW;          // up x forward product
  localparam int CW   = F + 33;           // side axis before normalising
  localparam int YPW  = 2 * ZW;
  localparam int YDW  = YPW + 1;
  localparam int H    = W / 2;            // split point of the eye for the dot products
  localparam int HW   = W - H;
  localparam int PHW  = AW + HW;
  localparam int PLW  = AW + H + 1;
  localparam int SHW  = PHW + 2;
  localparam int SLW  = PLW + 2;
  localparam int TW2  = AW + W + 4;
  localparam int E3W  = 3 * W;
  localparam int Z3W  = 3 * ZW;

  localparam logic signed [YDW-1:0] Y_RND = YDW'(1) <<< (F - 1);
  localparam logic signed [TW2-1:0] T_RND = TW2'(1) <<< (F - 1);

  function automatic logic signed [W-1:0] sat_w(input logic signed [TW2-1:0] v);
    if (&v[TW2-1:W-1] || ~|v[TW2-1:W-1]) sat_w = v[W-1:0];
    else if (v[TW2-1]) sat_w = {1'b1, {(W-1){1'b0}}};
    else sat_w = {1'b0, {(W-1){1'b1}}};
  endfunction

  // pipeline advances whenever the row holding register can take a new matrix
  logic               adv;
  logic               h_valid_r;
  logic [ROW_W-1:0]   row_r;

  assign adv      = !h_valid_r || (out_ready && row_r == LAST_ROW);
  assign in_ready = adv;

  // stage 0: forward direction before normalising
  logic                    v0_r;
  logic [2:0][W:0]         d0_r;
  logic [2:0][W-1:0]       eye0_r;
  logic [2:0][W-1:0]       up0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (adv) v0_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_r[0]   <= (W+1)'(in_data.target_x) - (W+1)'(in_data.eye_x);
      d0_r[1]   <= (W+1)'(in_data.target_y) - (W+1)'(in_data.eye_y);
      d0_r[2]   <= (W+1)'(in_data.target_z) - (W+1)'(in_data.eye_z);
      eye0_r[0] <= in_data.eye_x;
      eye0_r[1] <= in_data.eye_y;
      eye0_r[2] <= in_data.eye_z;
      up0_r[0]  <= in_data.up_x;
      up0_r[1]  <= in_data.up_y;
      up0_r[2]  <= in_data.up_z;
    end
  end

  // forward axis z
  logic                      n1_valid;
  logic signed [2:0][ZW-1:0] n1_z;
  logic [2*E3W-1:0]          n1_sb;

  lav_norm #(.VW(W + 1), .SBW(2 * E3W), .FRAC_BITS(F)) u_norm_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v0_r),
    .in_v     (d0_r),
    .in_sb    ({eye0_r, up0_r}),
    .out_valid(n1_valid),
    .out_u    (n1_z),
    .out_sb   (n1_sb)
  );

  // up direction scaled like a normaliser input, length left alone
  logic                    us_valid;
  logic [2:0][SCALE_W-1:0] us_mag;
  logic [2:0]              us_neg;
  logic                    us_zero;
  logic [E3W+Z3W-1:0]      us_sb;

  lav_scale #(.VW(W), .SBW(E3W + Z3W)) u_scale_up (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (n1_valid),
    .in_v     (n1_sb[E3W-1:0]),
    .in_sb    ({n1_sb[2*E3W-1:E3W], n1_z}),
    .out_valid(us_valid),
    .out_mag  (us_mag),
    .out_neg  (us_neg),
    .out_zero (us_zero),
    .out_sb   (us_sb)
  );

  // side axis: cross(up, z), products then differences
  logic signed [US-1:0]      usv [3];
  logic signed [2:0][ZW-1:0] zc;

  always_comb begin
    zc = us_sb[Z3W-1:0];
    for (int i = 0; i < 3; i++) begin
      if (us_zero) usv[i] = '0;
      else if (us_neg[i]) usv[i] = -$signed({1'b0, us_mag[i]});
      else usv[i] = $signed({1'b0, us_mag[i]});
    end
  end

  logic                      c1_v_r;
  logic signed [PXW-1:0]     cp1_r [6];
  logic [E3W+Z3W-1:0]        c1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c1_v_r <= 1'b0;
    else if (adv) c1_v_r <= us_valid;
  end

  // element selects of a packed array are unsigned, so signs are restored
  always_ff @(posedge clk) begin
    if (adv) begin
      cp1_r[0] <= usv[1] * $signed(zc[2]);
      cp1_r[1] <= usv[2] * $signed(zc[1]);
      cp1_r[2] <= usv[2] * $signed(zc[0]);
      cp1_r[3] <= usv[0] * $signed(zc[2]);
      cp1_r[4] <= usv[0] * $signed(zc[1]);
      cp1_r[5] <= usv[1] * $signed(zc[0]);
      c1_sb_r  <= us_sb;
    end
  end

  logic                  c2_v_r;
  logic [2:0][CW-1:0]    c2_r;
  logic [E3W+Z3W-1:0]    c2_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c2_v_r <= 1'b0;
    else if (adv) c2_v_r <= c1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c2_r[i] <= CW'(cp1_r[2*i]) - CW'(cp1_r[2*i+1]);
      end
      c2_sb_r <= c1_sb_r;
    end
  end

  // side axis x
  logic                      n2_valid;
  logic signed [2:0][ZW-1:0] n2_x;
  logic [E3W+Z3W-1:0]        n2_sb;

  lav_norm #(.VW(CW), .SBW(E3W + Z3W), .FRAC_BITS(F)) u_norm_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (c2_v_r),
    .in_v     (c2_r),
    .in_sb    (c2_sb_r),
    .out_valid(n2_valid),
    .out_u    (n2_x),
    .out_sb   (n2_sb)
  );

  // true up y = cross(z, x), rounded half up
  logic signed [2:0][ZW-1:0] zn;

  assign zn = n2_sb[Z3W-1:0];

  logic                      y1_v_r;
  logic signed [YPW-1:0]     yp1_r [6];
  logic signed [2:0][ZW-1:0] x1_r, z1_r;
  logic [2:0][W-1:0]         eye1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) y1_v_r <= 1'b0;
    else if (adv) y1_v_r <= n2_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yp1_r[0] <= $signed(zn[1]) * $signed(n2_x[2]);
      yp1_r[1] <= $signed(zn[2]) * $signed(n2_x[1]);
      yp1_r[2] <= $signed(zn[2]) * $signed(n2_x[0]);
      yp1_r[3] <= $signed(zn[0]) * $signed(n2_x[2]);
      yp1_r[4] <= $signed(zn[0]) * $signed(n2_x[1]);
      yp1_r[5] <= $signed(zn[1]) * $signed(n2_x[0]);
      x1_r     <= n2_x;
      z1_r     <= zn;
      eye1_r   <= n2_sb[E3W+Z3W-1:Z3W];
    end
  end

  logic signed [YDW-1:0] yd [3];
  logic signed [YDW-1:0] yr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      yd[i] = YDW'(yp1_r[2*i]) - YDW'(yp1_r[2*i+1]);
      yr[i] = (yd[i] + Y_RND) >>> F;
    end
  end

  logic                      y2_v_r;
  logic signed [AW-1:0]      ax2_r [3][3];   // axis, component
  logic [2:0][W-1:0]         eye2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) y2_v_r <= 1'b0;
    else if (adv) y2_v_r <= y1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        ax2_r[0][i] <= AW'($signed(x1_r[i]));
        ax2_r[1][i] <= yr[i][AW-1:0];
        ax2_r[2][i] <= AW'($signed(z1_r[i]));
      end
      eye2_r <= eye1_r;
    end
  end

  // row 3: exact dot products with the eye, split into high and low halves
  logic signed [HW-1:0] eh [3];
  logic signed [H:0]    el [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eh[i] = $signed(eye2_r[i][W-1:H]);
      el[i] = $signed({1'b0, eye2_r[i][H-1:0]});
    end
  end

  logic                 d1_v_r;
  logic signed [PHW-1:0] ph1_r [3][3];
  logic signed [PLW-1:0] pl1_r [3][3];
  logic signed [AW-1:0]  ax3_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r <= 1'b0;
    else if (adv) d1_v_r <= y2_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          ph1_r[a][i] <= ax2_r[a][i] * eh[i];
          pl1_r[a][i] <= ax2_r[a][i] * el[i];
        end
      end
      ax3_r <= ax2_r;
    end
  end

  logic                  d2_v_r;
  logic signed [SHW-1:0] hs2_r [3];
  logic signed [SLW-1:0] ls2_r [3];
  logic signed [AW-1:0]  ax4_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r <= 1'b0;
    else if (adv) d2_v_r <= d1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        hs2_r[a] <= SHW'(ph1_r[a][0]) + SHW'(ph1_r[a][1]) + SHW'(ph1_r[a][2]);
        ls2_r[a] <= SLW'(pl1_r[a][0]) + SLW'(pl1_r[a][1]) + SLW'(pl1_r[a][2]);
      end
      ax4_r <= ax3_r;
    end
  end

  // recombine, round half up, negate, saturate
  logic signed [TW2-1:0] dt  [3];
  logic signed [TW2-1:0] drn [3];
  logic signed [TW2-1:0] dng [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dt[a]  = (TW2'(hs2_r[a]) <<< H) + TW2'(ls2_r[a]);
      drn[a] = (dt[a] + T_RND) >>> F;
      dng[a] = -drn[a];
    end
  end

  // row holding register
  logic signed [W-1:0] hax_r [3][3];   // axis, row
  logic signed [W-1:0] hr3_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_valid_r <= 1'b0;
      row_r     <= '0;
    end else if (adv) begin
      h_valid_r <= d2_v_r;
      row_r     <= '0;
    end else if (out_valid && out_ready) begin
      row_r <= row_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        for (int r = 0; r < 3; r++) begin
          hax_r[a][r] <= sat_w(TW2'(ax4_r[a][r]));
        end
        hr3_r[a] <= sat_w(dng[a]);
      end
    end
  end

  assign out_valid = h_valid_r;

  always_comb begin
    out_data.row_index = row_r;
    out_data.last_row  = (row_r == LAST_ROW);
    if (row_r == LAST_ROW) begin
      out_data.col_zero = hr3_r[0];
      out_data.col_one  = hr3_r[1];
      out_data.col_two  = hr3_r[2];
    end else begin
      out_data.col_zero = hax_r[0][row_r];
      out_data.col_one  = hax_r[1][row_r];
      out_data.col_two  = hax_r[2][row_r];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lav_scale.sv -----
// pipelined power-of-two scaling of a 3-vector by its largest magnitude
`default_nettype none

module lav_scale #(
  parameter int VW  = 33,
  parameter int SBW = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [2:0][VW-1:0]             in_v,
  input  logic [SBW-1:0]                 in_sb,
  output logic                           out_valid,
  output logic [2:0][lav_pkg::SCALE_W-1:0] out_mag,
  output logic [2:0]                     out_neg,
  output logic                           out_zero,
  output logic [SBW-1:0]                 out_sb
);
  import lav_pkg::*;

  localparam int NG = (VW + 7) / 8;
  localparam int TW = NG * 8;
  localparam int PW = $clog2(TW);
  localparam int SHW = VW + SCALE_W - 1;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [2:0][VW-1:0] mag1_r, mag2_r, mag3_r, mag4_r;
  logic [2:0]         neg1_r, neg2_r, neg3_r, neg4_r, neg5_r;
  logic [SBW-1:0]     sb1_r, sb2_r, sb3_r, sb4_r, sb5_r;
  logic [VW-1:0]      top2_r;
  logic [NG-1:0]      nz3_r;
  logic [NG-1:0][2:0] pos3_r;
  logic [PW-1:0]      p4_r;
  logic               zero4_r, zero5_r;
  logic [2:0][SCALE_W-1:0] mag5_r;

  logic [2:0][VW-1:0] mag_nxt;
  logic [VW-1:0]      top_nxt;
  logic [TW-1:0]      topx;
  logic [NG-1:0]      nz_nxt;
  logic [NG-1:0][2:0] pos_nxt;
  logic [PW-1:0]      p_nxt;
  logic               zero_nxt;
  logic [SHW-1:0]     shv [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // magnitudes and signs
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = in_v[i][VW-1] ? VW'(0) - in_v[i] : in_v[i];
    end
  end

  // largest magnitude
  always_comb begin
    top_nxt = mag1_r[0];
    if (mag1_r[1] > top_nxt) top_nxt = mag1_r[1];
    if (mag1_r[2] > top_nxt) top_nxt = mag1_r[2];
  end

  // leading one per byte group
  always_comb begin
    topx = TW'(top2_r);
    for (int g = 0; g < NG; g++) begin
      nz_nxt[g]  = |topx[g*8 +: 8];
      pos_nxt[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (topx[g*8+b]) pos_nxt[g] = 3'(b);
      end
    end
  end

  // leading one of the word
  always_comb begin
    p_nxt    = '0;
    zero_nxt = 1'b1;
    for (int g = 0; g < NG; g++) begin
      if (nz3_r[g]) begin
        p_nxt    = PW'(g * 8) + PW'(pos3_r[g]);
        zero_nxt = 1'b0;
      end
    end
  end

  // one shifter covers both directions
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shv[i] = {mag4_r[i], {(SCALE_W-1){1'b0}}} >> p4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1_r[i] <= in_v[i][VW-1];
      end
      mag1_r  <= mag_nxt;
      sb1_r   <= in_sb;
      top2_r  <= top_nxt;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      sb2_r   <= sb1_r;
      nz3_r   <= nz_nxt;
      pos3_r  <= pos_nxt;
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      sb3_r   <= sb2_r;
      p4_r    <= p_nxt;
      zero4_r <= zero_nxt;
      mag4_r  <= mag3_r;
      neg4_r  <= neg3_r;
      sb4_r   <= sb3_r;
      for (int i = 0; i < 3; i++) begin
        mag5_r[i] <= shv[i][SCALE_W-1:0];
      end
      zero5_r <= zero4_r;
      neg5_r  <= neg4_r;
      sb5_r   <= sb4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_mag   = mag5_r;
  assign out_neg   = neg5_r;
  assign out_zero  = zero5_r;
  assign out_sb    = sb5_r;

endmodule

`default_nettype wire

// ----- hdl/lav_norm.sv -----
// pipelined normalisation of a 3-vector: scale, square sum, root, divide
`default_nettype none

module lav_norm #(
  parameter int VW        = 33,
  parameter int SBW       = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [2:0][VW-1:0]         in_v,
  input  logic [SBW-1:0]             in_sb,
  output logic                       out_valid,
  output logic signed [2:0][FRAC_BITS+1:0] out_u,
  output logic [SBW-1:0]             out_sb
);
  import lav_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int SQW  = 2 * SCALE_W;
  localparam int SUMW = SQW + 2;
  localparam int LW   = SCALE_W + 1;
  localparam int NSQ  = LW;
  localparam int QRW  = LW + 3;
  localparam int NW   = SCALE_W + F + 1;
  localparam int RW   = LW + 2;
  localparam int ND   = F + 1;
  localparam int ZW   = F + 2;

  logic                    s_valid;
  logic [2:0][SCALE_W-1:0] s_mag;
  logic [2:0]              s_neg;
  logic                    s_zero;
  logic [SBW-1:0]          s_sb;

  lav_scale #(.VW(VW), .SBW(SBW)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_v     (in_v),
    .in_sb    (in_sb),
    .out_valid(s_valid),
    .out_mag  (s_mag),
    .out_neg  (s_neg),
    .out_zero (s_zero),
    .out_sb   (s_sb)
  );

  // squares, then their sum
  logic                    n1_v_r;
  logic [2:0][SQW-1:0]     sq1_r;
  logic [2:0][SCALE_W-1:0] mag1_r;
  logic [2:0]              neg1_r;
  logic                    zero1_r;
  logic [SBW-1:0]          sb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) n1_v_r <= 1'b0;
    else if (en) n1_v_r <= s_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq1_r[i] <= SQW'(s_mag[i]) * SQW'(s_mag[i]);
      end
      mag1_r  <= s_mag;
      neg1_r  <= s_neg;
      zero1_r <= s_zero;
      sb1_r   <= s_sb;
    end
  end

  // root pipeline, one result bit a stage; index 0 holds the sum
  logic                    qv    [0:NSQ];
  logic [SUMW-1:0]         qrad  [0:NSQ];
  logic [QRW-1:0]          qrem  [0:NSQ];
  logic [LW-1:0]           qroot [0:NSQ];
  logic [2:0][SCALE_W-1:0] qmag  [0:NSQ];
  logic [2:0]              qneg  [0:NSQ];
  logic                    qzero [0:NSQ];
  logic [SBW-1:0]          qsb   [0:NSQ];

  always_ff @(posedge clk) begin
    if (!rst_n) qv[0] <= 1'b0;
    else if (en) qv[0] <= n1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qrad[0]  <= SUMW'(sq1_r[0]) + SUMW'(sq1_r[1]) + SUMW'(sq1_r[2]);
      qrem[0]  <= '0;
      qroot[0] <= '0;
      qmag[0]  <= mag1_r;
      qneg[0]  <= neg1_r;
      qzero[0] <= zero1_r;
      qsb[0]   <= sb1_r;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [QRW-1:0] r4;
    logic [QRW-1:0] trial;

    always_comb begin
      r4    = {qrem[k][QRW-3:0], qrad[k][SUMW-1 -: 2]};
      trial = {1'b0, qroot[k], 2'b01};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) qv[k+1] <= 1'b0;
      else if (en) qv[k+1] <= qv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qrad[k+1] <= {qrad[k][SUMW-3:0], 2'b00};
        if (r4 >= trial) begin
          qrem[k+1]  <= r4 - trial;
          qroot[k+1] <= {qroot[k][LW-2:0], 1'b1};
        end else begin
          qrem[k+1]  <= r4;
          qroot[k+1] <= {qroot[k][LW-2:0], 1'b0};
        end
        qmag[k+1]  <= qmag[k];
        qneg[k+1]  <= qneg[k];
        qzero[k+1] <= qzero[k];
        qsb[k+1]   <= qsb[k];
      end
    end
  end

  // three dividers in step, one quotient bit a stage; index 0 holds the setup
  logic              dv    [0:ND];
  logic [2:0][RW-1:0] drem [0:ND];
  logic [2:0][F:0]   dlo   [0:ND];
  logic [2:0][F:0]   dq    [0:ND];
  logic [LW-1:0]     dlen  [0:ND];
  logic [2:0]        dneg  [0:ND];
  logic              dzero [0:ND];
  logic [SBW-1:0]    dsb   [0:ND];

  logic [NW-1:0] num [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NW'({qmag[NSQ][i], {F{1'b0}}}) + NW'(qroot[NSQ] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) dv[0] <= 1'b0;
    else if (en) dv[0] <= qv[NSQ];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= RW'(num[i] >> (F + 1));
        dlo[0][i]  <= num[i][F:0];
        dq[0][i]   <= '0;
      end
      dlen[0]  <= qroot[NSQ];
      dneg[0]  <= qneg[NSQ];
      dzero[0] <= qzero[NSQ];
      dsb[0]   <= qsb[NSQ];
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [RW-1:0] r2 [3];

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        r2[i] = {drem[j][i][RW-2:0], dlo[j][i][F]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) dv[j+1] <= 1'b0;
      else if (en) dv[j+1] <= dv[j];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dlo[j+1][i] <= {dlo[j][i][F-1:0], 1'b0};
          if (r2[i] >= RW'(dlen[j])) begin
            drem[j+1][i] <= r2[i] - RW'(dlen[j]);
            dq[j+1][i]   <= {dq[j][i][F-1:0], 1'b1};
          end else begin
            drem[j+1][i] <= r2[i];
            dq[j+1][i]   <= {dq[j][i][F-1:0], 1'b0};
          end
        end
        dlen[j+1]  <= dlen[j];
        dneg[j+1]  <= dneg[j];
        dzero[j+1] <= dzero[j];
        dsb[j+1]   <= dsb[j];
      end
    end
  end

  // sign and zero-length vector
  logic                  o_v_r;
  logic signed [2:0][ZW-1:0] u_r;
  logic [SBW-1:0]        o_sb_r;
  logic signed [ZW-1:0]  qs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = $signed({1'b0, dq[ND][i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= dv[ND];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dzero[ND]) u_r[i] <= '0;
        else if (dneg[ND][i]) u_r[i] <= -qs[i];
        else u_r[i] <= qs[i];
      end
      o_sb_r <= dsb[ND];
    end
  end

  assign out_valid = o_v_r;
  assign out_u     = u_r;
  assign out_sb    = o_sb_r;

endmodule

`default_nettype wire
